// ===== hw/rtl/ptf_trim_pkg.sv =====
`default_nettype none
package ptf_trim_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    // sample format codes
    localparam logic [2:0] FMT_PCM8  = 3'd0;
    localparam logic [2:0] FMT_PCM16 = 3'd1;
    localparam logic [2:0] FMT_PCM24 = 3'd2;
    localparam logic [2:0] FMT_PCM32 = 3'd3;
    localparam logic [2:0] FMT_FLT32 = 3'd4;

    // register indexes
    localparam logic REG_SAMPLE_FORMAT = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    localparam logic [2:0] SAMPLE_FORMAT_RST = FMT_PCM16;
    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd2;

    localparam logic [31:0] FLOAT_ONE       = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_MINUS_ONE = 32'hBF80_0000;
    localparam logic [31:0] FLOAT_INF_BITS  = 32'h7F80_0000;

    typedef struct packed {
        logic [31:0] sample_raw;
        logic        restart;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] sample_value;
        logic [2:0]  channel;
        logic        frame_last;
    } out_beat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptf_trim_conv.sv =====
`default_nettype none
module ptf_trim_conv
(
    input  wire logic [2:0]  sample_format,
    input  wire logic [31:0] sample_raw,
    output logic      [31:0] sample_value
);

    logic [31:0] ival;
    logic [8:0]  scale;
    logic [31:0] mag;
    logic [4:0]  msb;
    logic [31:0] norm;
    logic [8:0]  expo;
    logic        rnd;
    logic [31:0] ires;
    logic [31:0] fmag;
    logic [31:0] fres;

    always_comb
    begin
        ival  = 32'd0;
        scale = 9'd0;
        case (sample_format)
            ptf_trim_pkg::FMT_PCM8:
            begin
                ival  = {24'd0, sample_raw[7:0]} - 32'd128;
                scale = 9'd7;
            end
            ptf_trim_pkg::FMT_PCM16:
            begin
                ival  = {{16{sample_raw[15]}}, sample_raw[15:0]};
                scale = 9'd15;
            end
            ptf_trim_pkg::FMT_PCM24:
            begin
                ival  = {{8{sample_raw[23]}}, sample_raw[23:0]};
                scale = 9'd23;
            end
            ptf_trim_pkg::FMT_PCM32:
            begin
                ival  = sample_raw;
                scale = 9'd31;
            end
            default:
            begin
                ival  = 32'd0;
                scale = 9'd0;
            end
        endcase
    end

    // integer to float, round to nearest even, then scaled by exponent
    always_comb
    begin
        mag = ival[31] ? (32'd0 - ival) : ival;
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                msb = 5'(i);
            end
        end
        norm = mag << (5'd31 - msb);
        expo = 9'd127 + {4'd0, msb} - scale;
        rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
        if (mag == 32'd0)
        begin
            ires = 32'd0;
        end
        else
        begin
            ires = {ival[31], expo[7:0], norm[30:8]} + {31'd0, rnd};
        end
    end

    always_comb
    begin
        fmag = {1'b0, sample_raw[30:0]};
        if (fmag > ptf_trim_pkg::FLOAT_INF_BITS)
        begin
            fres = ptf_trim_pkg::FLOAT_ONE;
        end
        else if (fmag > ptf_trim_pkg::FLOAT_ONE)
        begin
            fres = sample_raw[31] ? ptf_trim_pkg::FLOAT_MINUS_ONE : ptf_trim_pkg::FLOAT_ONE;
        end
        else
        begin
            fres = sample_raw;
        end
    end

    always_comb
    begin
        case (sample_format)
            ptf_trim_pkg::FMT_PCM8,
            ptf_trim_pkg::FMT_PCM16,
            ptf_trim_pkg::FMT_PCM24,
            ptf_trim_pkg::FMT_PCM32: sample_value = ires;
            ptf_trim_pkg::FMT_FLT32: sample_value = fres;
            default:                 sample_value = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ptf_trim_frame.sv =====
`default_nettype none
module ptf_trim_frame
#(
    parameter int MAX_CHANNELS = ptf_trim_pkg::MAX_CHANNELS_DEF,
    parameter int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire logic                         step,
    input  wire logic                         restart,
    input  wire logic [31:0]                  value,
    input  wire logic [3:0]                   channel_count,
    output logic                              need_load,
    output logic [MAX_CHANNELS-1:0][31:0]     load_frame,
    output logic [PW-1:0]                     load_last
);

    localparam int CW = ($clog2(MAX_CHANNELS + 1) > 4) ? $clog2(MAX_CHANNELS + 1) : 4;

    logic [31:0]   store_reg [MAX_CHANNELS];
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          armed_reg;
    logic          armed_next;
    logic          silent_reg;
    logic          silent_next;

    logic [PW-1:0] pos;
    logic          armed;
    logic          silent_now;
    logic [CW-1:0] n_eff;
    logic          complete;

    always_comb
    begin
        if (channel_count == 4'd0)
        begin
            n_eff = CW'(1);
        end
        else if (CW'(channel_count) > CW'(MAX_CHANNELS))
        begin
            n_eff = CW'(MAX_CHANNELS);
        end
        else
        begin
            n_eff = CW'(channel_count);
        end
    end

    always_comb
    begin
        pos        = restart ? '0 : pos_reg;
        armed      = restart | armed_reg;
        silent_now = (restart | silent_reg) & (value[30:0] == 31'd0);
        complete   = (CW'(pos) + CW'(1)) >= n_eff;
        need_load  = item_valid & complete & ~(armed & silent_now);

        pos_next    = pos + PW'(1);
        armed_next  = armed;
        silent_next = silent_now;
        if (complete)
        begin
            pos_next    = '0;
            silent_next = 1'b1;
            armed_next  = armed & silent_now;
        end

        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            load_frame[k] = (PW'(k) == pos) ? value : store_reg[k];
        end
        load_last = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            armed_reg  <= 1'b1;
            silent_reg <= 1'b1;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            armed_reg  <= armed_next;
            silent_reg <= silent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            store_reg[pos] <= value;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ptf_trim_emit.sv =====
`default_nettype none
module ptf_trim_emit
#(
    parameter int MAX_CHANNELS = ptf_trim_pkg::MAX_CHANNELS_DEF,
    parameter int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [MAX_CHANNELS-1:0][31:0] load_frame,
    input  wire logic [PW-1:0]                load_last,
    output logic                              free,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output ptf_trim_pkg::out_beat_t           out_data
);

    logic [31:0]   buf_reg [MAX_CHANNELS];
    logic [PW-1:0] idx_reg;
    logic [PW-1:0] idx_next;
    logic [PW-1:0] last_reg;
    logic          busy_reg;
    logic          busy_next;
    logic          beat;
    logic          at_last;

    assign at_last = (idx_reg == last_reg);
    assign beat    = busy_reg & ~out_stall;
    assign free    = ~busy_reg | (beat & at_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (beat)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + PW'(1);
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= load_last;
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                buf_reg[k] <= load_frame[k];
            end
        end
    end

    assign out_valid             = busy_reg;
    assign out_data.sample_value = buf_reg[idx_reg];
    assign out_data.channel      = 3'(idx_reg);
    assign out_data.frame_last   = at_last;

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= last_reg))
        else $error("read index past end of frame");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("frame loaded over a busy buffer");

    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !at_last) |=> busy_reg)
        else $error("burst ended before its last channel");

endmodule
`default_nettype wire

// ===== hw/rtl/pcm_to_float_start_silence_trim_unit.sv =====
`default_nettype none
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data (sample_raw, restart)
// out       output     out_valid/out_stall  out_data (sample_value, channel, frame_last)
// cfg       apb        psel/penable/pready  0x0 sample_format, 0x4 channel_count
//
// one sample per cycle enters unless stalled; conversion is combinational from in_reg
// a kept frame is copied to the output buffer and leaves one beat per unstalled cycle
// input stalls only when a frame completes while the previous burst is still draining
// reset: trimming armed, channel position zero, output buffer empty
module pcm_to_float_start_silence_trim_unit
#(
    parameter int MAX_CHANNELS = ptf_trim_pkg::MAX_CHANNELS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire ptf_trim_pkg::in_beat_t  in_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output ptf_trim_pkg::out_beat_t      out_data,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [2:0] fmt_reg;
    logic [3:0] cc_reg;
    logic       wr;

    ptf_trim_pkg::in_beat_t in_reg;
    logic       in_vreg;
    logic       advance;
    logic       accept;
    logic       need_load;
    logic       free;
    logic [31:0] value;
    logic [MAX_CHANNELS-1:0][31:0] load_frame;
    logic [PW-1:0] load_last;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= ptf_trim_pkg::SAMPLE_FORMAT_RST;
            cc_reg  <= ptf_trim_pkg::CHANNEL_COUNT_RST;
        end
        else if (wr)
        begin
            case (paddr[2])
                ptf_trim_pkg::REG_SAMPLE_FORMAT: fmt_reg <= pwdata[2:0];
                ptf_trim_pkg::REG_CHANNEL_COUNT: cc_reg  <= pwdata[3:0];
                default:                         fmt_reg <= fmt_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ptf_trim_pkg::REG_SAMPLE_FORMAT: prdata = {29'd0, fmt_reg};
            ptf_trim_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, cc_reg};
            default:                         prdata = 32'd0;
        endcase
    end

    assign advance  = in_vreg & (~need_load | free);
    assign in_stall = in_vreg & ~advance;
    assign accept   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vreg <= 1'b0;
        end
        else if (accept)
        begin
            in_vreg <= 1'b1;
        end
        else if (advance)
        begin
            in_vreg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
    end

    ptf_trim_conv u_conv
    (
        .sample_format (fmt_reg),
        .sample_raw    (in_reg.sample_raw),
        .sample_value  (value)
    );

    ptf_trim_frame #(.MAX_CHANNELS(MAX_CHANNELS), .PW(PW)) u_frame
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_vreg),
        .step          (advance),
        .restart       (in_reg.restart),
        .value         (value),
        .channel_count (cc_reg),
        .need_load     (need_load),
        .load_frame    (load_frame),
        .load_last     (load_last)
    );

    ptf_trim_emit #(.MAX_CHANNELS(MAX_CHANNELS), .PW(PW)) u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance & need_load),
        .load_frame (load_frame),
        .load_last  (load_last),
        .free       (free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire
